// ===== rtl/core/tda_pkg.sv =====
// ----------------------------------------------------------------------------
// tda_pkg
// Shared types, register map and the CORDIC arctangent table for the
// tilt deviation alarm.
// ----------------------------------------------------------------------------
`default_nettype none
package tda_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 16;
  localparam int INT_FRAC        = 16;
  localparam int OUT_SHIFT       = INT_FRAC - ANGLE_FRAC_BITS;

  localparam int OPW = 25;   // CORDIC operand width
  localparam int VW  = 27;   // CORDIC working vector width
  localparam int AW  = 26;   // internal angle width
  localparam int SQW = 33;   // y*y + z*z
  localparam int RTW = 25;   // square root result

  typedef logic signed [15:0] accel_t;
  typedef logic signed [15:0] roll_t;
  typedef logic signed [14:0] pitch_t;
  typedef logic signed [OPW-1:0] opnd_t;
  typedef logic signed [AW-1:0]  angle_t;

  localparam angle_t DEG90 = angle_t'(90 <<< INT_FRAC);

  localparam int ROLL_LIM  = 180 << ANGLE_FRAC_BITS;
  localparam int PITCH_LIM = 90 << ANGLE_FRAC_BITS;

  localparam logic [1:0] REG_THRESH   = 2'd0;
  localparam logic [1:0] REG_OVERRIDE = 2'd1;
  localparam logic [1:0] REG_LEVEL    = 2'd2;

  localparam logic [14:0] THRESH_RESET = 15'(20 << ANGLE_FRAC_BITS);

  function automatic angle_t atan_tab(input logic [4:0] i);
    angle_t v;
    unique case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tda_if.sv =====
// ----------------------------------------------------------------------------
// tda_sample_if / tda_result_if
// Valid/ready channels for accelerometer samples and alarm results.
// ----------------------------------------------------------------------------
`default_nettype none
interface tda_sample_if;
  logic                  valid;
  logic                  ready;
  tda_pkg::accel_t       accel_x;
  tda_pkg::accel_t       accel_y;
  tda_pkg::accel_t       accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tda_result_if;
  logic                  valid;
  logic                  ready;
  logic                  alarm;
  tda_pkg::roll_t        roll_angle;
  tda_pkg::pitch_t       pitch_angle;
  logic                  baseline_taken;
  modport source (output valid, alarm, roll_angle, pitch_angle, baseline_taken,
                  input ready);
  modport sink (input valid, alarm, roll_angle, pitch_angle, baseline_taken,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tilt_deviation_alarm_top.sv =====
// ----------------------------------------------------------------------------
// tilt_deviation_alarm_top
// Roll and pitch from one accelerometer beat, compared against a baseline.
// Steps: squaring of y and z (S_MULY, S_MULZ), the square root overlapping
// the roll CORDIC, the 16-step pitch CORDIC and the hand-off to the result
// register. The next sample is taken once the result is registered, and a
// stalled result holds the block. An override item goes straight from
// acceptance to S_FIN. Reset (rst, synchronous) clears the baseline and
// loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module tilt_deviation_alarm_top (
  input  wire logic        clk,
  input  wire logic        rst,
  tda_sample_if.sink       in_ch,
  tda_result_if.source     out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tda_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULY  = 3'd1;
  localparam logic [2:0] S_MULZ  = 3'd2;
  localparam logic [2:0] S_ROLL  = 3'd3;
  localparam logic [2:0] S_RWAIT = 3'd4;
  localparam logic [2:0] S_PWAIT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]  state;
  logic [14:0] thresh;
  logic        override;
  logic        level;
  logic        ovr_item;
  accel_t      ax, ay, az;
  logic [SQW-1:0] sq;
  logic signed [31:0] prod;
  accel_t      mul_a;
  roll_t       roll;
  roll_t       base_roll;
  pitch_t      base_pitch;
  logic        base_valid;
  logic        cor_start, cor_busy, sqr_start, sqr_busy;
  opnd_t       cor_num, cor_den;
  angle_t      cor_acc;
  logic [RTW-1:0] mag;
  roll_t       roll_next;
  pitch_t      pitch_next;
  logic signed [16:0] dr, dp;
  logic        alarm_next;

  // APB register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh   <= THRESH_RESET;
      override <= 1'b0;
      level    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_THRESH:   thresh   <= pwdata[14:0];
        REG_OVERRIDE: override <= pwdata[0];
        REG_LEVEL:    level    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESH:   prdata = {17'h0, thresh};
      REG_OVERRIDE: prdata = {31'h0, override};
      REG_LEVEL:    prdata = {31'h0, level};
      default:      prdata = '0;
    endcase
  end

  // Rounds an internal angle to the output format and saturates it.
  function automatic logic signed [17:0] to_out(input angle_t a, input int lim);
    logic signed [AW:0]   t;
    logic signed [17:0]   r;
    t = {a[AW-1], a} + (AW+1)'(1 <<< (OUT_SHIFT - 1));
    r = 18'(t >>> OUT_SHIFT);
    if (r > 18'(lim)) r = 18'(lim);
    if (r < -18'(lim)) r = -18'(lim);
    return r;
  endfunction

  assign mul_a = (state == S_MULY) ? ay : az;
  assign prod  = mul_a * mul_a;

  assign cor_start = (state == S_ROLL) || (state == S_RWAIT && !sqr_busy && !cor_busy);
  assign sqr_start = (state == S_ROLL);
  assign cor_num   = (state == S_ROLL) ? {ay[15], ay, 8'h00} : -{ax[15], ax, 8'h00};
  assign cor_den   = (state == S_ROLL) ? {az[15], az, 8'h00} : opnd_t'(mag);

  tda_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .num(cor_num), .den(cor_den),
    .busy(cor_busy), .acc(cor_acc)
  );

  tda_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sqr_start), .sq(sq), .busy(sqr_busy), .root(mag)
  );

  assign pitch_next = pitch_t'(to_out(cor_acc, PITCH_LIM));
  assign dr = 17'(roll) - 17'(base_roll);
  assign dp = 17'(pitch_next) - 17'(base_pitch);
  assign alarm_next = ((dr[16] ? -dr : dr) > {2'b00, thresh})
                   || ((dp[16] ? -dp : dp) > {2'b00, thresh});
  assign roll_next = roll_t'(to_out(cor_acc, ROLL_LIM));

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base_valid   <= 1'b0;
      base_roll    <= '0;
      base_pitch   <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // In S_FIN the valid flag is handled by the state itself.
      if (out_ch.valid && out_ch.ready && state != S_FIN) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            ax       <= in_ch.accel_x;
            ay       <= in_ch.accel_y;
            az       <= in_ch.accel_z;
            ovr_item <= override;
            state    <= override ? S_FIN : S_MULY;
          end
        end
        S_MULY: begin
          sq    <= SQW'(unsigned'(prod));
          state <= S_MULZ;
        end
        S_MULZ: begin
          sq    <= sq + SQW'(unsigned'(prod));
          state <= S_ROLL;
        end
        S_ROLL: state <= S_RWAIT;
        S_RWAIT: begin
          if (!sqr_busy && !cor_busy) begin
            roll  <= roll_next;
            state <= S_PWAIT;
          end
        end
        S_PWAIT: if (!cor_busy) state <= S_FIN;
        S_FIN: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state        <= S_IDLE;
            if (ovr_item) begin
              out_ch.alarm          <= level;
              out_ch.roll_angle     <= '0;
              out_ch.pitch_angle    <= '0;
              out_ch.baseline_taken <= 1'b0;
            end else begin
              out_ch.roll_angle  <= roll;
              out_ch.pitch_angle <= pitch_next;
              if (!base_valid) begin
                base_valid            <= 1'b1;
                base_roll             <= roll;
                base_pitch            <= pitch_next;
                out_ch.alarm          <= 1'b0;
                out_ch.baseline_taken <= 1'b1;
              end else begin
                out_ch.alarm          <= alarm_next;
                out_ch.baseline_taken <= 1'b0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tda_isqrt.sv =====
// ----------------------------------------------------------------------------
// tda_isqrt
// Digit-serial integer square root of (sq << 16), two radicand bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tda_isqrt (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [tda_pkg::SQW-1:0] sq,
  output logic                         busy,
  output logic [tda_pkg::RTW-1:0]      root
);
  import tda_pkg::*;

  localparam int NW = 2 * RTW;
  localparam int RW = RTW + 2;

  logic [NW-1:0] nsh;
  logic [RW-1:0] rem;
  logic [4:0]    cnt;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;

  assign rem_sh = {rem[RW-3:0], nsh[NW-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      nsh  <= {(NW-SQW-16)'(0), sq, 16'h0000};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      nsh <= {nsh[NW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RTW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RTW-2:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'(RTW - 1)) busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tda_cordic.sv =====
// ----------------------------------------------------------------------------
// tda_cordic
// Iterative vectoring CORDIC: atan2(num, den) in degrees, 16 fraction bits,
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tda_cordic (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire tda_pkg::opnd_t  num,
  input  wire tda_pkg::opnd_t  den,
  output logic                 busy,
  output tda_pkg::angle_t      acc
);
  import tda_pkg::*;

  logic signed [VW-1:0] x;
  logic signed [VW-1:0] y;
  logic [4:0]           step;
  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;
  logic signed [VW-1:0] num_w;
  logic signed [VW-1:0] den_w;

  assign xs    = x >>> step;
  assign ys    = y >>> step;
  assign num_w = VW'(num);
  assign den_w = VW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      acc  <= '0;
    end else if (start) begin
      step <= '0;
      if (num == '0) begin
        acc  <= (den[OPW-1]) ? angle_t'(DEG90 <<< 1) : '0;
        busy <= 1'b0;
      end else if (den == '0) begin
        acc  <= (num[OPW-1]) ? -DEG90 : DEG90;
        busy <= 1'b0;
      end else begin
        busy <= 1'b1;
        // A vector in the left half plane is first turned by a right angle.
        if (den[OPW-1]) begin
          if (!num[OPW-1]) begin
            x <= num_w; y <= -den_w; acc <= DEG90;
          end else begin
            x <= -num_w; y <= den_w; acc <= -DEG90;
          end
        end else begin
          x <= den_w; y <= num_w; acc <= '0;
        end
      end
    end else if (busy) begin
      if (!y[VW-1]) begin
        x <= x + ys; y <= y - xs; acc <= acc + atan_tab(step);
      end else begin
        x <= x - ys; y <= y + xs; acc <= acc - atan_tab(step);
      end
      step <= step + 5'd1;
      if (step == 5'(CORDIC_STEPS - 1)) busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire
